// ===== sv/float_integer_power_top_macros.svh =====
// Assertion helpers for the file that checks this block.
`ifndef FLOAT_INTEGER_POWER_TOP_MACROS_SVH
`define FLOAT_INTEGER_POWER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FIP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fip_pkg.sv =====
// ----------------------------------------------------------------------------
// fip_pkg
// Shared constants, command and status types for the binary64 power block.
// ----------------------------------------------------------------------------
package fip_pkg;

	localparam int EXP_BITS   = 32;
	localparam int BIT_CNT_W  = $clog2(EXP_BITS + 1);
	localparam int QUO_BITS   = 56;
	localparam int STEP_CNT_W = $clog2(QUO_BITS);
	localparam int PP_LAST    = 3;

	localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
	localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SHIFT,
		OP_SETX,
		OP_MUL_START,
		OP_PP,
		OP_NORM,
		OP_ROUND,
		OP_DIV_START,
		OP_DIV_PRE,
		OP_DIV_STEP,
		OP_DIV_LOAD,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       mul_xr;     // multiply x by r instead of r by r
		logic       mul_rt;     // multiply r by the saved r (second half of a set bit)
		logic       shift_mag;  // consume one exponent bit
		logic [1:0] pp_idx;     // partial product select
	} cmd_t;

	typedef struct packed {
		logic mag_msb;
		logic neg;
		logic special;
		logic norm_done;
		logic pre_done;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/fip_dp.sv =====
// ----------------------------------------------------------------------------
// fip_dp
// Datapath: binary64 multiply (four partial products), restoring reciprocal,
// shared normalize and round-to-nearest-even, exponent bit register.
// ----------------------------------------------------------------------------
module fip_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [63:0]                   base_bits,
	input  logic signed [31:0]            exponent,
	input  fip_pkg::cmd_t                 cmd,
	output fip_pkg::stat_t                stat,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [63:0]                   result_bits
);

	logic [63:0]                   x_q, r_q, t_q, spec_val_q, res_q;
	logic [fip_pkg::EXP_BITS-1:0]  mag_q;
	logic                          neg_q, sign_q, special_q, sticky_q, out_valid_q;
	logic [52:0]                   ma_q, mb_q;
	logic signed [13:0]            e_q;
	logic [105:0]                  p_q;
	logic [53:0]                   rem_q;
	logic [fip_pkg::QUO_BITS-1:0]  q_q;

	// load
	logic [fip_pkg::EXP_BITS-1:0]  e_in;
	logic                          e_neg;

	// operand decode
	logic [63:0]        opa, opb;
	logic [10:0]        ea, eb, ea_eff, eb_eff;
	logic [51:0]        fa, fb;
	logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, mul_sign;
	logic               mul_spec, div_spec;
	logic [63:0]        mul_spec_val, div_spec_val;
	logic signed [13:0] mul_e;

	// partial products
	logic [26:0]  pp_a, pp_b;
	logic [53:0]  pp_prod;
	logic [6:0]   pp_sh;

	// normalize
	logic               e_le0;
	logic signed [13:0] rshift;
	logic               rs_big;
	logic [6:0]         rs_k;
	logic [105:0]       rs_mask;

	// round
	logic         rnd_inc, rnd_ovf;
	logic [63:0]  rnd_bits;

	// divide step
	logic         dv_ge;
	logic [53:0]  dv_sub;

	assign e_in  = fip_pkg::EXP_BITS'(exponent);
	assign e_neg = e_in[fip_pkg::EXP_BITS-1];

	// set bit: x*r first (old r kept in t_q), then (x*r)*t_q
	assign opa = cmd.mul_xr ? x_q : r_q;
	assign opb = cmd.mul_rt ? t_q : r_q;
	assign ea = opa[62:52];
	assign eb = opb[62:52];
	assign fa = opa[51:0];
	assign fb = opb[51:0];
	assign a_nan  = (&ea) && (|fa);
	assign b_nan  = (&eb) && (|fb);
	assign a_inf  = (&ea) && !(|fa);
	assign b_inf  = (&eb) && !(|fb);
	assign a_zero = !(|ea) && !(|fa);
	assign b_zero = !(|eb) && !(|fb);
	assign ea_eff = (ea == 11'd0) ? 11'd1 : ea;
	assign eb_eff = (eb == 11'd0) ? 11'd1 : eb;
	assign mul_sign = opa[63] ^ opb[63];
	assign mul_e = $signed({3'b000, ea_eff}) + $signed({3'b000, eb_eff}) - 14'sd1022;

	always_comb begin
		mul_spec     = 1'b1;
		mul_spec_val = fip_pkg::CANON_NAN;
		if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
			mul_spec_val = fip_pkg::CANON_NAN;
		end else if (a_inf || b_inf) begin
			mul_spec_val = {mul_sign, fip_pkg::INF_MAG};
		end else if (a_zero || b_zero) begin
			mul_spec_val = {mul_sign, 63'd0};
		end else begin
			mul_spec = 1'b0;
		end
	end

	// reciprocal operand is r
	always_comb begin
		div_spec     = 1'b1;
		div_spec_val = fip_pkg::CANON_NAN;
		if (b_nan) begin
			div_spec_val = fip_pkg::CANON_NAN;
		end else if (b_inf) begin
			div_spec_val = {opb[63], 63'd0};
		end else if (b_zero) begin
			div_spec_val = {opb[63], fip_pkg::INF_MAG};
		end else begin
			div_spec = 1'b0;
		end
	end

	// low halves are 27 bits, high halves 26 bits
	assign pp_a    = cmd.pp_idx[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
	assign pp_b    = cmd.pp_idx[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
	assign pp_prod = pp_a * pp_b;
	assign pp_sh   = (cmd.pp_idx[1] ? 7'd27 : 7'd0) + (cmd.pp_idx[0] ? 7'd27 : 7'd0);

	assign e_le0   = e_q[13] || (e_q == 14'sd0);
	assign rshift  = 14'sd1 - e_q;
	assign rs_big  = rshift > 14'sd105;
	assign rs_k    = rshift[6:0];
	assign rs_mask = (106'd1 << rs_k) - 106'd1;

	assign rnd_inc  = p_q[52] && ((|p_q[51:0]) || sticky_q || p_q[53]);
	assign rnd_ovf  = e_q >= 14'sd2047;
	assign rnd_bits = {sign_q, (p_q[105] ? e_q[10:0] : 11'd0), p_q[104:53]}
	                  + {63'd0, rnd_inc};

	assign dv_ge  = rem_q >= {1'b0, ma_q};
	assign dv_sub = dv_ge ? (rem_q - {1'b0, ma_q}) : rem_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			fip_pkg::OP_LOAD: begin
				x_q   <= base_bits;
				r_q   <= fip_pkg::ONE_BITS;
				neg_q <= e_neg;
				mag_q <= e_neg ? (fip_pkg::EXP_BITS'(0) - e_in) : e_in;
			end
			fip_pkg::OP_SHIFT: begin
				mag_q <= mag_q << 1;
			end
			fip_pkg::OP_SETX: begin
				r_q   <= x_q;
				mag_q <= mag_q << 1;
			end
			fip_pkg::OP_MUL_START: begin
				if (cmd.shift_mag) begin
					mag_q <= mag_q << 1;
				end
				if (cmd.mul_xr) begin
					t_q <= r_q;
				end
				special_q  <= mul_spec;
				spec_val_q <= mul_spec_val;
				sign_q     <= mul_sign;
				ma_q       <= {ea != 11'd0, fa};
				mb_q       <= {eb != 11'd0, fb};
				e_q        <= mul_e;
				p_q        <= '0;
				sticky_q   <= 1'b0;
			end
			fip_pkg::OP_PP: begin
				p_q <= p_q + (106'(pp_prod) << pp_sh);
			end
			fip_pkg::OP_NORM: begin
				if (e_le0) begin
					if (rs_big) begin
						p_q      <= '0;
						sticky_q <= sticky_q || (|p_q);
					end else begin
						p_q      <= p_q >> rs_k;
						sticky_q <= sticky_q || (|(p_q & rs_mask));
					end
					e_q <= 14'sd1;
				end else if (!p_q[105] && (e_q != 14'sd1)) begin
					p_q <= p_q << 1;
					e_q <= e_q - 14'sd1;
				end
			end
			fip_pkg::OP_ROUND: begin
				if (special_q) begin
					r_q <= spec_val_q;
				end else if (rnd_ovf) begin
					r_q <= {sign_q, fip_pkg::INF_MAG};
				end else begin
					r_q <= rnd_bits;
				end
			end
			fip_pkg::OP_DIV_START: begin
				special_q  <= div_spec;
				spec_val_q <= div_spec_val;
				sign_q     <= opb[63];
				ma_q       <= {eb != 11'd0, fb};
				e_q        <= $signed({3'b000, eb_eff});
				rem_q      <= 54'd1 << 52;
				q_q        <= '0;
			end
			fip_pkg::OP_DIV_PRE: begin
				ma_q <= ma_q << 1;
				e_q  <= e_q - 14'sd1;
			end
			fip_pkg::OP_DIV_STEP: begin
				q_q   <= {q_q[fip_pkg::QUO_BITS-2:0], dv_ge};
				rem_q <= {dv_sub[52:0], 1'b0};
			end
			fip_pkg::OP_DIV_LOAD: begin
				p_q      <= {q_q, 50'd0};
				e_q      <= 14'sd2046 - e_q;
				sticky_q <= |rem_q;
			end
			fip_pkg::OP_FINISH: begin
				res_q <= (r_q[62:0] > fip_pkg::INF_MAG) ? fip_pkg::CANON_NAN : r_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == fip_pkg::OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.mag_msb   = mag_q[fip_pkg::EXP_BITS-1];
	assign stat.neg       = neg_q;
	assign stat.special   = special_q;
	assign stat.norm_done = special_q || (!e_le0 && (p_q[105] || (e_q == 14'sd1)));
	assign stat.pre_done  = special_q || ma_q[52];
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign result_bits = res_q;

endmodule

// ===== sv/fip_ctrl.sv =====
// ----------------------------------------------------------------------------
// fip_ctrl
// Sequencer: scans exponent bits, steps multiplies, reciprocal and rounding.
// ----------------------------------------------------------------------------
module fip_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  fip_pkg::stat_t stat,
	output fip_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_NEXT,
		S_SQ,
		S_MUL,
		S_NORM,
		S_ROUND,
		S_DPRE,
		S_DSTEP,
		S_DLOAD,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic [fip_pkg::BIT_CNT_W-1:0]   bit_cnt_q;
	logic [fip_pkg::STEP_CNT_W-1:0]  step_q;
	logic                            pend_sq_q, div_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd.op        = fip_pkg::OP_NONE;
		cmd.mul_xr    = 1'b0;
		cmd.mul_rt    = 1'b0;
		cmd.shift_mag = 1'b0;
		cmd.pp_idx    = step_q[1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = fip_pkg::OP_LOAD;
				end
			end
			S_SCAN: begin
				if (bit_cnt_q != '0) begin
					cmd.op = stat.mag_msb ? fip_pkg::OP_SETX : fip_pkg::OP_SHIFT;
				end
			end
			S_NEXT: begin
				if (bit_cnt_q != '0) begin
					cmd.op        = fip_pkg::OP_MUL_START;
					cmd.mul_xr    = stat.mag_msb;
					cmd.shift_mag = 1'b1;
				end else if (stat.neg) begin
					cmd.op = fip_pkg::OP_DIV_START;
				end
			end
			S_SQ: begin
				cmd.op     = fip_pkg::OP_MUL_START;
				cmd.mul_rt = 1'b1;
			end
			S_MUL: begin
				if (!stat.special) begin
					cmd.op = fip_pkg::OP_PP;
				end
			end
			S_NORM: begin
				if (!stat.norm_done) begin
					cmd.op = fip_pkg::OP_NORM;
				end
			end
			S_ROUND:  cmd.op = fip_pkg::OP_ROUND;
			S_DPRE: begin
				if (!stat.pre_done) begin
					cmd.op = fip_pkg::OP_DIV_PRE;
				end
			end
			S_DSTEP:  cmd.op = fip_pkg::OP_DIV_STEP;
			S_DLOAD:  cmd.op = fip_pkg::OP_DIV_LOAD;
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.op = fip_pkg::OP_FINISH;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bit_cnt_q <= '0;
			step_q    <= '0;
			pend_sq_q <= 1'b0;
			div_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q   <= S_SCAN;
						bit_cnt_q <= fip_pkg::BIT_CNT_W'(fip_pkg::EXP_BITS);
						pend_sq_q <= 1'b0;
						div_q     <= 1'b0;
					end
				end
				S_SCAN: begin
					if (bit_cnt_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						bit_cnt_q <= bit_cnt_q - 1'b1;
						if (stat.mag_msb) begin
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					if (bit_cnt_q != '0) begin
						bit_cnt_q <= bit_cnt_q - 1'b1;
						pend_sq_q <= stat.mag_msb;
						step_q    <= '0;
						state_q   <= S_MUL;
					end else if (stat.neg) begin
						div_q   <= 1'b1;
						state_q <= S_DPRE;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_SQ: begin
					pend_sq_q <= 1'b0;
					step_q    <= '0;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					if (stat.special) begin
						state_q <= S_ROUND;
					end else if (step_q == fip_pkg::STEP_CNT_W'(fip_pkg::PP_LAST)) begin
						state_q <= S_NORM;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_NORM: begin
					if (stat.norm_done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					priority if (pend_sq_q) begin
						state_q <= S_SQ;
					end else if (div_q) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_DPRE: begin
					if (stat.special) begin
						state_q <= S_ROUND;
					end else if (stat.pre_done) begin
						step_q  <= '0;
						state_q <= S_DSTEP;
					end
				end
				S_DSTEP: begin
					if (step_q == fip_pkg::STEP_CNT_W'(fip_pkg::QUO_BITS - 1)) begin
						state_q <= S_DLOAD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DLOAD:  state_q <= S_NORM;
				S_FINISH: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/float_integer_power_top.sv =====
// Sequence: accept, scan the exponent bits down to the leading one, then
//   per later bit one multiply (clear) or two (set), each made of start, 4 partial
//   products, normalize and round (special operands skip the partial products and normalize;
//   subnormals add normalize shifts), the reciprocal for a negative power, then issue and finish.
// Throughput: one transaction at a time; next one accepted after the result registers.
// Reset: arst_n clears the sequencer and the output valid asynchronously.
// ----------------------------------------------------------------------------
// float_integer_power_top
// Binary64 base raised to a signed integer power by square-and-multiply,
// with a restoring reciprocal for negative powers. All rounding is RNE.
// ----------------------------------------------------------------------------
`include "float_integer_power_top_macros.svh"

module float_integer_power_top (
	input  logic               clk,
	input  logic               arst_n,
	// input transaction
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [63:0]        base_bits,
	input  logic signed [31:0] exponent,
	// output transaction
	output logic               out_valid,
	input  logic               out_stall,
	output logic [63:0]        result_bits
);

	fip_pkg::cmd_t  cmd;
	fip_pkg::stat_t stat;

	// Sequencer: walks the exponent bits from the top, skips leading zeros
	// (r stays 1.0 there), then issues r*r for a clear bit, and x*r followed
	// by a multiply with the old r for a set bit.
	fip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: operand registers, multiply/reciprocal/round hardware and
	// the output register, which holds a finished result until taken.
	fip_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_bits   (base_bits),
		.exponent    (exponent),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_bits (result_bits)
	);

	// An accepted transaction makes the block busy in the next cycle.
	`FIP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
	// A new result only appears out of a busy sequencer.
	`FIP_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result without work")

endmodule

// ===== sim/float_integer_power_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_integer_power_top_tb
// Drives binary64 base / signed exponent pairs into the power block with
// random gaps and output stalls, predicts each result with host double
// arithmetic in the same square-and-multiply order, and checks in order.
// ----------------------------------------------------------------------------
module float_integer_power_top_tb;

	localparam int  CLK_HALF    = 2;
	localparam int  DRAIN_CYC   = 1500;    // worst latency with subnormals, plus margin
	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  RAND_ITEMS  = 630;
	localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
	localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;

	typedef struct {
		logic [63:0] base;
		logic [31:0] pow;
	} pow_req_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [63:0]        base_bits;
	logic signed [31:0] exponent;
	logic               out_valid;
	logic               out_stall;
	logic [63:0]        result_bits;

	pow_req_t    pending_reqs[$];
	logic [63:0] expected_powers[$];
	int          mismatches;
	int          cycle_cnt;
	int          send_gap;
	int          stall_len;
	bit          stim_done;

	float_integer_power_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.base_bits  (base_bits),
		.exponent   (exponent),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_bits(result_bits)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// binary64 power, same operation order as the block: scan magnitude MSB first,
	// r = (x*r)*r on a set bit, r = r*r on a clear bit, then reciprocal if negative
	function automatic logic [63:0] power_of(input logic [63:0] base, input logic [31:0] pow);
		logic        neg;
		logic [31:0] mag;
		real         x;
		real         r;
		logic [63:0] rb;
		neg = pow[31];
		mag = neg ? (32'd0 - pow) : pow;
		if (mag == 32'd0)
			return fip_pkg::ONE_BITS;
		x = $bitstoreal(base);
		r = 1.0;
		for (int i = 31; i >= 0; i--) begin
			if (mag[i])
				r = (x * r) * r;
			else
				r = r * r;
		end
		rb = $realtobits(r);
		if (neg) begin
			// reciprocal of a signed zero is the same-signed infinity
			if ((rb & ~SIGN_MASK) == 64'd0)
				rb = (rb & SIGN_MASK) | POS_INF;
			else
				rb = $realtobits(1.0 / r);
		end
		// any NaN comes out as the canonical quiet NaN
		if ((rb & ~SIGN_MASK) > POS_INF)
			rb = fip_pkg::CANON_NAN;
		return rb;
	endfunction

	// idle length: half none, mostly short, a few long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 50)
			return 0;
		if (p < 93)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// base values biased toward interesting ranges
	function automatic logic [63:0] pick_base();
		logic [63:0] b;
		int          p;
		b = {$urandom, $urandom};
		p = $urandom_range(99);
		if (p < 45)
			b[62:52] = 11'd1023 + 11'($urandom_range(4)) - 11'd2;  // near one
		else if (p < 55)
			b[62:52] = 11'd0;                                       // subnormal / zero
		else if (p < 62)
			b[62:52] = 11'h7FF;                                     // inf / NaN
		else if (p < 66)
			b[51:0] = 52'd0;                                        // exact powers of two
		return b;
	endfunction

	function automatic logic [31:0] pick_pow();
		int p;
		p = $urandom_range(99);
		if (p < 60)
			return 32'($urandom_range(64)) - 32'd32;
		if (p < 80)
			return 32'($urandom_range(2400)) - 32'd1200;
		return $urandom;
	endfunction

	task automatic add_req(input logic [63:0] b, input logic [31:0] n);
		pow_req_t req;
		req.base = b;
		req.pow  = n;
		pending_reqs.push_back(req);
	endtask

	// Stimulus: directed corners first, then random pairs
	initial begin
		stim_done = 1'b0;
		arst_n    = 1'b0;
		// zero exponent, including a NaN base
		add_req(64'h7FF8_0000_DEAD_BEEF, 32'd0);
		add_req(64'h4000_0000_0000_0000, 32'd0);
		// exponent extremes
		add_req(64'h3FF0_0000_0000_0000, 32'h7FFF_FFFF);
		add_req(64'hBFF0_0000_0000_0000, 32'h7FFF_FFFF);
		add_req(64'hBFF0_0000_0000_0000, 32'h8000_0000);
		add_req(64'h4000_0000_0000_0000, 32'h8000_0000);   // 2^huge -> inf -> 0
		add_req(64'h3FE0_0000_0000_0000, 32'h8000_0000);   // underflow -> reciprocal of zero
		add_req(64'hBFE0_0000_0000_0000, 32'h7FFF_FFFF);
		// signed zeros and reciprocal of zero
		add_req(64'h0000_0000_0000_0000, 32'hFFFF_FFFF);
		add_req(64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
		add_req(64'h8000_0000_0000_0000, 32'hFFFF_FFFE);
		add_req(64'h8000_0000_0000_0000, 32'd3);
		// infinities and NaN payloads
		add_req(64'h7FF0_0000_0000_0000, 32'hFFFF_FFFF);
		add_req(64'hFFF0_0000_0000_0000, 32'd3);
		add_req(64'hFFF0_0000_0000_0000, 32'hFFFF_FFFD);
		add_req(64'hFFFF_FFFF_FFFF_FFFF, 32'd5);
		add_req(64'h7FF0_0000_0000_0001, 32'hFFFF_FFFF);
		// subnormals and extremes of the finite range
		add_req(64'h0000_0000_0000_0001, 32'd1);
		add_req(64'h0000_0000_0000_0001, 32'hFFFF_FFFF);
		add_req(64'h000F_FFFF_FFFF_FFFF, 32'd2);
		add_req(64'h7FEF_FFFF_FFFF_FFFF, 32'd1);
		add_req(64'h7FEF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		add_req(64'h3FF0_0000_0000_0001, 32'd1000000);
		add_req(64'hC008_0000_0000_0000, 32'hFFFF_FFF9);
		for (int i = 0; i < RAND_ITEMS; i++)
			add_req(pick_base(), pick_pow());
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		stim_done = 1'b1;
	end

	// Driver: a held transaction stays put while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			base_bits <= '0;
			exponent  <= '0;
			send_gap  <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				expected_powers.push_back(power_of(base_bits, exponent));
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				pow_req_t req;
				req = pending_reqs.pop_front();
				in_valid  <= 1'b1;
				base_bits <= req.base;
				exponent  <= req.pow;
				send_gap  <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random stalls on the result side, in-order compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_len  <= 0;
			mismatches <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_powers.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result %h", result_bits);
					mismatches <= mismatches + 1;
				end else begin
					logic [63:0] want;
					want = expected_powers.pop_front();
					if (result_bits !== want) begin
						if (mismatches < 10)
							$display("result_bits mismatch: expected %h actual %h",
								want, result_bits);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				stall_len <= stall_len - 1;
			end else begin
				out_stall <= 1'b0;
				stall_len <= pick_gap();
			end
		end
	end

	// Completion: all sent, all results back, then a drain window
	initial begin
		wait (stim_done);
		wait (pending_reqs.size() == 0 && !in_valid && expected_powers.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && expected_powers.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial cycle_cnt = 0;

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fip_pkg.sv
sv/fip_dp.sv
sv/fip_ctrl.sv
sv/float_integer_power_top.sv
sim/float_integer_power_top_tb.sv
